>>> hw/rtl/dmes_pkg.sv
// Shared types and constants for the directed multigraph edge store.
`timescale 1ns / 1ps
package dmes_pkg;
    localparam int unsigned REQ_W  = 3;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned NODE_W = 8;
    localparam int unsigned AMT_W  = 7;
    localparam int unsigned DEG_W  = 14;
    localparam int unsigned TOT_W  = 15;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_NODES = 3'd0,
        REQ_ADD_LINK  = 3'd1,
        REQ_DEL_LINK  = 3'd2,
        REQ_TEST_LINK = 3'd3,
        REQ_DEL_NODE  = 3'd4,
        REQ_DEGREE    = 3'd5
    } t_req;

    localparam logic [STAT_W-1:0] ST_OK   = 3'd0;
    localparam logic [STAT_W-1:0] ST_DEST = 3'd1;
    localparam logic [STAT_W-1:0] ST_SRC  = 3'd2;
    localparam logic [STAT_W-1:0] ST_SELF = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,    // sweep matrix and counters after reset
        S_IDLE,
        S_READ,     // matrix and counter read issued
        S_EXEC,     // read data valid, decide and write
        S_DN_FIX,   // node delete: degree fix per k
        S_DN_COPY,  // node delete: read shifted source entry
        S_DN_WR,    // node delete: write shifted entry
        S_DN_CNT,   // node delete: shift counters, clear last row and column
        S_OUT       // result waits for receiver
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic rd_cell;
        logic exec;
        logic fix_rd;
        logic fix_wr;
        logic copy_rd;
        logic copy_wr;
        logic cnt_rd;
        logic cnt_step;
        logic finish_dn;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic is_del_node;
        logic del_ok;
        logic fix_done;
        logic copy_done;
        logic cnt_done;
    } t_stat;
endpackage

>>> hw/rtl/directed_multigraph_edge_store_core.sv
// Top level of the directed multigraph edge store.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on the s_axis group; one result per request leaves on
//   m_axis. s_axis_tdata from bit 0: req_type[2:0], dest_node[10:3],
//   src_node[18:11], node_amount[25:19]. m_axis_tdata from bit 0:
//   status[2:0], node_index[10:3], link_found[11], in_degree[25:12],
//   out_degree[39:26], total_degree[54:40].
//   One request is handled at a time. Append, link, test and degree
//   requests pass through a registered matrix and counter read and then
//   the decide-and-write step before their result is valid; a new
//   request is taken only after that result has been taken.
//   Node delete walks the matrix through the degree fix, the shifted
//   entries and the freed row and column before it gives its result.
//   After reset the matrix is swept clear, with tready low.
//   A result holds on m_axis until taken; no new request is taken meanwhile.
module directed_multigraph_edge_store_core #(
    parameter int unsigned MAX_NODES = 64,
    parameter int unsigned MULT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_type, dest_node, src_node, node_amount
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // status, node_index, link_found, in/out/total
);
    dmes_pkg::t_cmd  w_cmd;
    dmes_pkg::t_stat w_stat;
    logic [dmes_pkg::STAT_W-1:0] w_status;
    logic [dmes_pkg::NODE_W-1:0] w_idx;
    logic                        w_found;
    logic [dmes_pkg::DEG_W-1:0]  w_ind, w_outd;
    logic [dmes_pkg::TOT_W-1:0]  w_tot;
    logic [5:0]                  w_unused;

    assign w_unused = s_axis_tdata[31:26];

    dmes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    dmes_dp #(.MAX_NODES(MAX_NODES), .MULT_BITS(MULT_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n && (w_unused == w_unused)),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_req_type     (s_axis_tdata[2:0]),
        .i_dest_node    (s_axis_tdata[10:3]),
        .i_src_node     (s_axis_tdata[18:11]),
        .i_node_amount  (s_axis_tdata[25:19]),
        .o_status       (w_status),
        .o_node_index   (w_idx),
        .o_link_found   (w_found),
        .o_in_degree    (w_ind),
        .o_out_degree   (w_outd),
        .o_total_degree (w_tot)
    );

    assign m_axis_tdata = {1'b0, w_tot, w_outd, w_ind, w_found, w_idx, w_status};
endmodule

>>> hw/rtl/dmes_ctrl.sv
// Controller state machine of the directed multigraph edge store.
`timescale 1ns / 1ps
module dmes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dmes_pkg::t_stat  i_stat,
    output dmes_pkg::t_cmd   o_cmd
);
    dmes_pkg::t_state r_state, n_state;
    logic             r_fix_ph, n_fix_ph;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dmes_pkg::S_CLEAR;
            r_fix_ph <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fix_ph <= n_fix_ph;
        end
    end

    // Next state
    always_comb begin
        n_state  = r_state;
        n_fix_ph = r_fix_ph;
        unique case (r_state)
            dmes_pkg::S_CLEAR:   if (i_stat.clr_done) n_state = dmes_pkg::S_IDLE;
            dmes_pkg::S_IDLE:    if (i_in_valid) n_state = dmes_pkg::S_READ;
            dmes_pkg::S_READ:    n_state = dmes_pkg::S_EXEC;
            dmes_pkg::S_EXEC: begin
                if (i_stat.is_del_node && i_stat.del_ok) begin
                    n_state  = dmes_pkg::S_DN_FIX;
                    n_fix_ph = 1'b0;
                end else begin
                    n_state = dmes_pkg::S_OUT;
                end
            end
            dmes_pkg::S_DN_FIX: begin
                n_fix_ph = !r_fix_ph;
                if (r_fix_ph && i_stat.fix_done) n_state = dmes_pkg::S_DN_COPY;
            end
            dmes_pkg::S_DN_COPY: n_state = dmes_pkg::S_DN_WR;
            dmes_pkg::S_DN_WR:
                n_state = i_stat.copy_done ? dmes_pkg::S_DN_CNT : dmes_pkg::S_DN_COPY;
            dmes_pkg::S_DN_CNT: begin
                n_fix_ph = !r_fix_ph;
                if (r_fix_ph && i_stat.cnt_done) n_state = dmes_pkg::S_OUT;
            end
            dmes_pkg::S_OUT:     if (i_out_ready) n_state = dmes_pkg::S_IDLE;
            default:             n_state = dmes_pkg::S_IDLE;
        endcase
    end

    // Drive commands
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            dmes_pkg::S_CLEAR:  o_cmd.clr_step = 1'b1;
            dmes_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            dmes_pkg::S_READ:    o_cmd.rd_cell = 1'b1;
            dmes_pkg::S_EXEC:    o_cmd.exec = 1'b1;
            dmes_pkg::S_DN_FIX: begin
                o_cmd.fix_rd = !r_fix_ph;
                o_cmd.fix_wr = r_fix_ph;
            end
            dmes_pkg::S_DN_COPY: o_cmd.copy_rd = 1'b1;
            dmes_pkg::S_DN_WR:   o_cmd.copy_wr = 1'b1;
            dmes_pkg::S_DN_CNT: begin
                o_cmd.cnt_rd    = !r_fix_ph;
                o_cmd.cnt_step  = r_fix_ph;
                o_cmd.finish_dn = r_fix_ph && i_stat.cnt_done;
            end
            dmes_pkg::S_OUT:     o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // Requests are only taken while idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result pending");
    a_exec_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_cell |=> o_cmd.exec) else $error("exec must follow read");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
endmodule

>>> hw/rtl/dmes_dp.sv
// Datapath of the directed multigraph edge store: link matrix, degree counters.
`timescale 1ns / 1ps
module dmes_dp #(
    parameter int unsigned MAX_NODES = 64,
    parameter int unsigned MULT_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dmes_pkg::t_cmd                 i_cmd,
    output dmes_pkg::t_stat                o_stat,
    input  logic [dmes_pkg::REQ_W-1:0]     i_req_type,
    input  logic [dmes_pkg::NODE_W-1:0]    i_dest_node,
    input  logic [dmes_pkg::NODE_W-1:0]    i_src_node,
    input  logic [dmes_pkg::AMT_W-1:0]     i_node_amount,
    output logic [dmes_pkg::STAT_W-1:0]    o_status,
    output logic [dmes_pkg::NODE_W-1:0]    o_node_index,
    output logic                           o_link_found,
    output logic [dmes_pkg::DEG_W-1:0]     o_in_degree,
    output logic [dmes_pkg::DEG_W-1:0]     o_out_degree,
    output logic [dmes_pkg::TOT_W-1:0]     o_total_degree
);
    localparam int unsigned IW   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned CW   = $clog2(MAX_NODES + 1);
    localparam int unsigned AW   = 2 * IW;
    localparam int unsigned CNTW = 2 * IW + MULT_BITS + 1;
    localparam logic [MULT_BITS-1:0] LINK_MAX = '1;
    localparam logic [CW-1:0] NMAX = CW'(MAX_NODES);

    // Link-count matrix, address {dest, src}
    logic [MULT_BITS-1:0] r_mat [0:(1 << AW)-1];
    logic [CNTW-1:0]      r_in_cnt  [0:MAX_NODES-1];
    logic [CNTW-1:0]      r_out_cnt [0:MAX_NODES-1];

    logic [CW-1:0]                 r_total;
    logic [dmes_pkg::REQ_W-1:0]    r_req;
    logic [dmes_pkg::NODE_W-1:0]   r_d, r_s;
    logic [dmes_pkg::AMT_W-1:0]    r_amt;
    logic [MULT_BITS-1:0]          r_rd;
    logic [MULT_BITS-1:0]          r_rd2;
    logic [CNTW-1:0]               r_ci, r_co;
    logic [AW-1:0]                 r_clr;
    logic [IW-1:0]                 r_k, r_r, r_c;
    logic [CW-1:0]                 r_x;

    logic          w_d_ok, w_s_ok;
    logic [IW-1:0] w_rs, w_cs;
    logic [IW-1:0] w_out_sel, w_ks;
    logic [CW-1:0] w_nm1;
    logic [CW:0]   w_room_sum;

    assign w_d_ok = {1'b0, r_d} < (dmes_pkg::NODE_W+1)'(r_total);
    assign w_s_ok = {1'b0, r_s} < (dmes_pkg::NODE_W+1)'(r_total);
    assign w_nm1  = r_total - CW'(1);
    assign w_rs   = ({1'b0, r_r} < (IW+1)'(r_x)) ? r_r : r_r + IW'(1);
    assign w_cs   = ({1'b0, r_c} < (IW+1)'(r_x)) ? r_c : r_c + IW'(1);
    assign w_ks   = ({1'b0, r_k} < (IW+1)'(r_x)) ? r_k : r_k + IW'(1);
    assign w_room_sum = (CW+1)'(r_total) + (CW+1)'(r_amt);
    assign w_out_sel  = (r_req == dmes_pkg::REQ_DEGREE) ? r_d[IW-1:0] : r_s[IW-1:0];

    logic [IW-1:0] w_xi;
    assign w_xi = r_x[IW-1:0];

    // Status toward the controller
    always_comb begin
        o_stat             = '0;
        o_stat.clr_done    = (r_clr == AW'((1 << AW) - 1));
        o_stat.is_del_node = (r_req == dmes_pkg::REQ_DEL_NODE);
        o_stat.del_ok      = w_d_ok;
        o_stat.fix_done    = ({1'b0, r_k} == (IW+1)'(w_nm1));
        o_stat.copy_done   = ((CW)'(r_r) + CW'(2) >= r_total)
                             && ((CW)'(r_c) + CW'(2) >= r_total);
        o_stat.cnt_done    = ((CW)'(r_k) == w_nm1);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + AW'(1);
            if (i_cmd.exec && r_req == dmes_pkg::REQ_ADD_NODES) begin
                r_total <= (w_room_sum > (CW+1)'(NMAX)) ? NMAX : w_room_sum[CW-1:0];
            end
            if (i_cmd.finish_dn) r_total <= w_nm1;
        end
    end

    // Matrix: one write per cycle; one registered read, two in the degree fix
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_mat[r_clr] <= '0;
        if (i_cmd.rd_cell) r_rd <= r_mat[{r_d[IW-1:0], r_s[IW-1:0]}];
        if (i_cmd.exec && w_d_ok && w_s_ok && r_d != r_s
                && r_req == dmes_pkg::REQ_ADD_LINK && r_rd != LINK_MAX)
            r_mat[{r_d[IW-1:0], r_s[IW-1:0]}] <= r_rd + MULT_BITS'(1);
        if (i_cmd.exec && w_d_ok && w_s_ok
                && r_req == dmes_pkg::REQ_DEL_LINK && r_rd != '0)
            r_mat[{r_d[IW-1:0], r_s[IW-1:0]}] <= r_rd - MULT_BITS'(1);
        // degree fix reads M[x][k] and M[k][x] together
        if (i_cmd.fix_rd) r_rd  <= r_mat[{w_xi, r_k}];
        if (i_cmd.fix_rd) r_rd2 <= r_mat[{r_k, w_xi}];
        if (i_cmd.copy_rd) r_rd <= r_mat[{w_rs, w_cs}];
        if (i_cmd.copy_wr) r_mat[{r_r, r_c}] <= r_rd;
        // clear freed column entry, then freed row entry, one per phase
        if (i_cmd.cnt_rd) r_mat[{r_k, w_nm1[IW-1:0]}] <= '0;
        if (i_cmd.cnt_step) r_mat[{w_nm1[IW-1:0], r_k}] <= '0;
    end

    // Degree counters, request capture and iteration indices
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && r_clr < AW'(MAX_NODES)) begin
            r_in_cnt[r_clr[IW-1:0]]  <= '0;
            r_out_cnt[r_clr[IW-1:0]] <= '0;
        end
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_d   <= i_dest_node;
            r_s   <= i_src_node;
            r_amt <= i_node_amount;
        end
        // registered counter reads, one address per array
        if (i_cmd.rd_cell) begin
            r_ci <= r_in_cnt[r_d[IW-1:0]];
            r_co <= r_out_cnt[w_out_sel];
        end
        if (i_cmd.fix_rd) begin
            r_ci <= r_in_cnt[r_k];
            r_co <= r_out_cnt[r_k];
        end
        if (i_cmd.cnt_rd) begin
            r_ci <= r_in_cnt[w_ks];
            r_co <= r_out_cnt[w_ks];
        end
        if (i_cmd.exec) begin
            r_x <= CW'(r_d[IW-1:0]);
            r_k <= '0;
            r_r <= '0;
            r_c <= '0;
            if (w_d_ok && w_s_ok && r_d != r_s && r_rd != LINK_MAX
                    && r_req == dmes_pkg::REQ_ADD_LINK) begin
                r_in_cnt[r_d[IW-1:0]]  <= r_ci + CNTW'(1);
                r_out_cnt[r_s[IW-1:0]] <= r_co + CNTW'(1);
            end
            if (w_d_ok && w_s_ok && r_rd != '0 && r_req == dmes_pkg::REQ_DEL_LINK) begin
                r_in_cnt[r_d[IW-1:0]]  <= r_ci - CNTW'(1);
                r_out_cnt[r_s[IW-1:0]] <= r_co - CNTW'(1);
            end
        end
        if (i_cmd.fix_wr) begin
            if (r_k != w_xi) begin
                r_out_cnt[r_k] <= r_co - CNTW'(r_rd);
                r_in_cnt[r_k]  <= r_ci - CNTW'(r_rd2);
            end
            r_k <= r_k + IW'(1);
        end
        if (i_cmd.copy_wr) begin
            if ((CW)'(r_c) + CW'(2) >= r_total) begin
                r_c <= '0;
                r_r <= r_r + IW'(1);
            end else begin
                r_c <= r_c + IW'(1);
            end
        end
        if (i_cmd.copy_wr && (CW)'(r_c) + CW'(2) >= r_total
                && (CW)'(r_r) + CW'(2) >= r_total) begin
            r_k <= '0;
        end
        if (i_cmd.cnt_step) begin
            if ((CW)'(r_k) < w_nm1) begin
                r_in_cnt[r_k]  <= r_ci;
                r_out_cnt[r_k] <= r_co;
            end else begin
                r_in_cnt[r_k]  <= '0;
                r_out_cnt[r_k] <= '0;
            end
            r_k <= r_k + IW'(1);
        end
    end

    // Result register
    logic [CNTW:0] w_sum;
    assign w_sum = {1'b0, r_ci} + {1'b0, r_co};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_status       <= dmes_pkg::ST_OK;
            o_node_index   <= '0;
            o_link_found   <= 1'b0;
            o_in_degree    <= '0;
            o_out_degree   <= '0;
            o_total_degree <= '0;
            case (r_req)
                dmes_pkg::REQ_ADD_NODES: begin
                    if (w_room_sum > (CW+1)'(NMAX)) begin
                        o_status     <= dmes_pkg::ST_FULL;
                        o_node_index <= dmes_pkg::NODE_W'(NMAX - CW'(1));
                    end else if (w_room_sum == '0) begin
                        o_status <= dmes_pkg::ST_NONE;
                    end else begin
                        o_node_index <= dmes_pkg::NODE_W'(w_room_sum - (CW+1)'(1));
                    end
                end
                dmes_pkg::REQ_ADD_LINK, dmes_pkg::REQ_DEL_LINK,
                dmes_pkg::REQ_TEST_LINK: begin
                    if (!w_d_ok) o_status <= dmes_pkg::ST_DEST;
                    else if (!w_s_ok) o_status <= dmes_pkg::ST_SRC;
                    else if (r_req == dmes_pkg::REQ_ADD_LINK) begin
                        if (r_d == r_s) o_status <= dmes_pkg::ST_SELF;
                        else if (r_rd == LINK_MAX) o_status <= dmes_pkg::ST_FULL;
                        else o_node_index <= r_s;
                    end else if (r_req == dmes_pkg::REQ_DEL_LINK) begin
                        if (r_rd != '0) o_link_found <= 1'b1;
                        else o_status <= dmes_pkg::ST_NONE;
                    end else begin
                        o_link_found <= (r_rd != '0);
                    end
                end
                dmes_pkg::REQ_DEL_NODE: begin
                    if (!w_d_ok) o_status <= dmes_pkg::ST_DEST;
                    else o_node_index <= r_d;
                end
                dmes_pkg::REQ_DEGREE: begin
                    if (!w_d_ok) o_status <= dmes_pkg::ST_DEST;
                    else begin
                        o_in_degree <= (r_ci > CNTW'(16383))
                            ? dmes_pkg::DEG_W'(16383) : r_ci[dmes_pkg::DEG_W-1:0];
                        o_out_degree <= (r_co > CNTW'(16383))
                            ? dmes_pkg::DEG_W'(16383) : r_co[dmes_pkg::DEG_W-1:0];
                        o_total_degree <= (w_sum > (CNTW+1)'(32767))
                            ? dmes_pkg::TOT_W'(32767) : w_sum[dmes_pkg::TOT_W-1:0];
                    end
                end
                default: o_status <= dmes_pkg::ST_NONE;
            endcase
        end
    end

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= NMAX) else $error("node total over capacity");
    a_finish_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish_dn |=> r_total == $past(r_total) - CW'(1))
        else $error("delete did not shrink graph");
    a_fix_before_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix_wr |-> r_total != '0) else $error("fix on empty graph");
endmodule

>>> verif/testbench.sv
// Self-checking testbench for the directed multigraph edge store core.
`timescale 1ns / 1ps
module testbench;
    localparam int unsigned NODES    = 64;
    localparam int unsigned LINK_TOP = 255;
    localparam int unsigned DEG_TOP  = 16383;
    localparam int unsigned TOT_TOP  = 32767;
    localparam int unsigned RANDOM_ITEMS = 790;
    localparam int unsigned HAMMER_ITEMS = 260;

    // One result of the block, split into its fields
    typedef struct {
        logic [dmes_pkg::STAT_W-1:0] status;
        logic [dmes_pkg::NODE_W-1:0] node_index;
        logic                        link_found;
        logic [dmes_pkg::DEG_W-1:0]  in_degree;
        logic [dmes_pkg::DEG_W-1:0]  out_degree;
        logic [dmes_pkg::TOT_W-1:0]  total_degree;
    } t_result;

    // Graph mirror plus the queue of results still owed by the block
    class graph_scoreboard;
        int unsigned node_total;
        int unsigned link_cnt [NODES][NODES];   // [dest][src]
        int unsigned in_cnt [NODES];
        int unsigned out_cnt [NODES];
        t_result     pending [$];
        int unsigned errors;

        function new();
            node_total = 0;
            errors = 0;
            foreach (link_cnt[d, s]) link_cnt[d][s] = 0;
            foreach (in_cnt[k]) begin
                in_cnt[k] = 0;
                out_cnt[k] = 0;
            end
        endfunction

        // Drop node x with all its links, then shift higher nodes down
        function void drop_node(int unsigned x);
            int unsigned n;
            int unsigned rs;
            int unsigned cs;
            n = node_total;
            for (int unsigned k = 0; k < n; k++) begin
                if (k != x) begin
                    out_cnt[k] -= link_cnt[x][k];
                    in_cnt[k]  -= link_cnt[k][x];
                end
            end
            for (int unsigned r = 0; r + 1 < n; r++) begin
                rs = (r < x) ? r : r + 1;
                for (int unsigned c = 0; c + 1 < n; c++) begin
                    cs = (c < x) ? c : c + 1;
                    link_cnt[r][c] = link_cnt[rs][cs];
                end
                in_cnt[r]  = in_cnt[rs];
                out_cnt[r] = out_cnt[rs];
            end
            for (int unsigned k = 0; k < n; k++) begin
                link_cnt[n-1][k] = 0;
                link_cnt[k][n-1] = 0;
            end
            in_cnt[n-1]  = 0;
            out_cnt[n-1] = 0;
            node_total = n - 1;
        endfunction

        // Apply one accepted request and queue the result it owes
        function void note_request(logic [31:0] word);
            logic [dmes_pkg::REQ_W-1:0] req;
            int unsigned d;
            int unsigned s;
            int unsigned amt;
            int unsigned room;
            int unsigned tot;
            t_result res;
            req = word[2:0];
            d   = {24'd0, word[10:3]};
            s   = {24'd0, word[18:11]};
            amt = {25'd0, word[25:19]};
            res = '{dmes_pkg::ST_OK, '0, 1'b0, '0, '0, '0};
            case (req)
                dmes_pkg::REQ_ADD_NODES: begin
                    room = NODES - node_total;
                    if (amt > room) begin
                        amt = room;
                        res.status = dmes_pkg::ST_FULL;
                    end
                    node_total += amt;
                    if (node_total == 0) res.status = dmes_pkg::ST_NONE;
                    else res.node_index = dmes_pkg::NODE_W'(node_total - 1);
                end
                dmes_pkg::REQ_ADD_LINK, dmes_pkg::REQ_DEL_LINK,
                dmes_pkg::REQ_TEST_LINK: begin
                    if (d >= node_total) res.status = dmes_pkg::ST_DEST;
                    else if (s >= node_total) res.status = dmes_pkg::ST_SRC;
                    else if (req == dmes_pkg::REQ_ADD_LINK) begin
                        if (d == s) res.status = dmes_pkg::ST_SELF;
                        else if (link_cnt[d][s] >= LINK_TOP) res.status = dmes_pkg::ST_FULL;
                        else begin
                            link_cnt[d][s]++;
                            in_cnt[d]++;
                            out_cnt[s]++;
                            res.node_index = dmes_pkg::NODE_W'(s);
                        end
                    end else if (req == dmes_pkg::REQ_DEL_LINK) begin
                        if (link_cnt[d][s] > 0) begin
                            link_cnt[d][s]--;
                            in_cnt[d]--;
                            out_cnt[s]--;
                            res.link_found = 1'b1;
                        end else res.status = dmes_pkg::ST_NONE;
                    end else begin
                        res.link_found = (link_cnt[d][s] > 0);
                    end
                end
                dmes_pkg::REQ_DEL_NODE: begin
                    if (d >= node_total) res.status = dmes_pkg::ST_DEST;
                    else begin
                        drop_node(d);
                        res.node_index = dmes_pkg::NODE_W'(d);
                    end
                end
                dmes_pkg::REQ_DEGREE: begin
                    if (d >= node_total) res.status = dmes_pkg::ST_DEST;
                    else begin
                        tot = in_cnt[d] + out_cnt[d];
                        res.in_degree  = dmes_pkg::DEG_W'((in_cnt[d] > DEG_TOP) ?
                                                          DEG_TOP : in_cnt[d]);
                        res.out_degree = dmes_pkg::DEG_W'((out_cnt[d] > DEG_TOP) ?
                                                          DEG_TOP : out_cnt[d]);
                        res.total_degree = dmes_pkg::TOT_W'((tot > TOT_TOP) ?
                                                            TOT_TOP : tot);
                    end
                end
                default: res.status = dmes_pkg::ST_NONE;
            endcase
            pending = {pending, res};
        endfunction

        // Compare one result taken from the block with the oldest one owed
        function void check_result(logic [55:0] word);
            t_result want;
            t_result got;
            got.status       = word[2:0];
            got.node_index   = word[10:3];
            got.link_found   = word[11];
            got.in_degree    = word[25:12];
            got.out_degree   = word[39:26];
            got.total_degree = word[54:40];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.node_index !== want.node_index) begin
                $display("%0t: node_index exp %0d got %0d", $time,
                         want.node_index, got.node_index);
                errors++;
            end
            if (got.link_found !== want.link_found) begin
                $display("%0t: link_found exp %0d got %0d", $time,
                         want.link_found, got.link_found);
                errors++;
            end
            if (got.in_degree !== want.in_degree) begin
                $display("%0t: in_degree exp %0d got %0d", $time,
                         want.in_degree, got.in_degree);
                errors++;
            end
            if (got.out_degree !== want.out_degree) begin
                $display("%0t: out_degree exp %0d got %0d", $time,
                         want.out_degree, got.out_degree);
                errors++;
            end
            if (got.total_degree !== want.total_degree) begin
                $display("%0t: total_degree exp %0d got %0d", $time,
                         want.total_degree, got.total_degree);
                errors++;
            end
            if (word[55] !== 1'b0) begin
                $display("%0t: pad bit exp 0 got %b", $time, word[55]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // req_type, dest_node, src_node, node_amount
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // status, node_index, link_found, in/out/total

    graph_scoreboard board = new();
    int unsigned     sent_total = 0;
    int unsigned     taken_total = 0;

    directed_multigraph_edge_store_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Offer one request, wait for acceptance, then idle for a random gap
    task automatic send_request(input logic [dmes_pkg::REQ_W-1:0] req,
                                input int unsigned dest,
                                input int unsigned src, input int unsigned amt);
        int unsigned gap;
        s_axis_tdata  <= {6'b0, amt[6:0], src[7:0], dest[7:0], req};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(s_axis_tdata);
        sent_total++;
        // no idling in some stretches
        gap = ((sent_total % 200) < 40) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Pick a node index: mostly in range, sometimes anything
    function automatic int unsigned pick_node();
        if (board.node_total == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, board.node_total - 1);
    endfunction

    // Draw one random request shaped around the current graph
    task automatic send_random();
        int unsigned r;
        int unsigned amt;
        r = $urandom_range(0, 99);
        if (board.node_total < 2 || (r < 8 && board.node_total <= 28)) begin
            amt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 4);
            send_request(dmes_pkg::REQ_ADD_NODES, $urandom_range(0, 255),
                         $urandom_range(0, 255), amt);
        end else if (r < 8 || (r >= 70 && r < 76)) begin
            send_request(dmes_pkg::REQ_DEL_NODE, pick_node(), $urandom_range(0, 255), 0);
        end else if (r < 40) begin
            send_request(dmes_pkg::REQ_ADD_LINK, pick_node(), pick_node(),
                         $urandom_range(0, 127));
        end else if (r < 55) begin
            send_request(dmes_pkg::REQ_DEL_LINK, pick_node(), pick_node(), 0);
        end else if (r < 70) begin
            send_request(dmes_pkg::REQ_TEST_LINK, pick_node(), pick_node(), 0);
        end else if (r < 92) begin
            send_request(dmes_pkg::REQ_DEGREE, pick_node(), $urandom_range(0, 255), 0);
        end else if (r < 96) begin
            send_request(dmes_pkg::REQ_W'($urandom_range(1, 5)), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 127));
        end else begin
            send_request(dmes_pkg::REQ_W'($urandom_range(6, 7)), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 127));
        end
    endtask

    // Stimulus and end of run
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty graph corners, then a full graph
        send_request(dmes_pkg::REQ_DEGREE, 0, 0, 0);
        send_request(dmes_pkg::REQ_TEST_LINK, 0, 0, 0);
        send_request(dmes_pkg::REQ_ADD_NODES, 0, 0, 0);
        send_request(dmes_pkg::REQ_DEL_NODE, 0, 0, 0);
        send_request(dmes_pkg::REQ_ADD_NODES, 255, 255, 127);
        send_request(dmes_pkg::REQ_ADD_LINK, 63, 0, 0);
        send_request(dmes_pkg::REQ_ADD_LINK, 0, 63, 0);
        send_request(dmes_pkg::REQ_ADD_LINK, 0, 63, 0);
        send_request(dmes_pkg::REQ_ADD_LINK, 5, 5, 0);
        send_request(dmes_pkg::REQ_ADD_LINK, 64, 3, 0);
        send_request(dmes_pkg::REQ_ADD_LINK, 3, 200, 0);
        send_request(dmes_pkg::REQ_DEL_LINK, 5, 5, 0);
        send_request(dmes_pkg::REQ_DEL_LINK, 0, 63, 0);
        send_request(dmes_pkg::REQ_TEST_LINK, 0, 63, 0);
        send_request(dmes_pkg::REQ_TEST_LINK, 1, 2, 0);
        send_request(dmes_pkg::REQ_DEGREE, 63, 0, 0);
        send_request(dmes_pkg::REQ_DEGREE, 0, 0, 0);
        send_request(dmes_pkg::REQ_DEL_NODE, 63, 0, 0);
        send_request(dmes_pkg::REQ_DEL_NODE, 0, 0, 0);
        send_request(dmes_pkg::REQ_DEL_NODE, 255, 0, 0);
        send_request(dmes_pkg::REQ_DEGREE, 255, 0, 0);
        send_request(dmes_pkg::REQ_ADD_NODES, 0, 0, 70);
        send_request(3'd6, 1, 2, 3);
        send_request(3'd7, 255, 255, 127);
        // shrink the graph so node deletes stay cheap
        while (board.node_total > 24) send_request(dmes_pkg::REQ_DEL_NODE, 0, 0, 0);

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                // drive one link count into saturation
                for (int unsigned j = 0; j < HAMMER_ITEMS; j++)
                    send_request(dmes_pkg::REQ_ADD_LINK, 1, 0, 0);
                send_request(dmes_pkg::REQ_DEGREE, 1, 0, 0);
                send_request(dmes_pkg::REQ_DEL_NODE, 0, 0, 0);
            end
            send_random();
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end

    // Result side: random stalls, one long hold-off to back the block up
    initial begin
        int unsigned stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken_total == 300) stall = 400;
            else stall = ((taken_total % 250) < 50) ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            board.check_result(m_axis_tdata);
            taken_total++;
        end
    end

    // Hard limit on run time
    initial begin
        #40_000_000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
